// ===== rtl/dec7_pkg.sv =====
package dec7_pkg;

    // reset value of the dwell register
    localparam logic [15:0] DWELL_RESET = 16'd1000;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // highest scan index, the scan wraps to zero after it
    localparam logic [2:0] SCAN_LAST = 3'd7;

    // input beat: one sample of both pins
    typedef struct packed {
        logic pin0_level;
        logic pin1_level;
    } in_t;

    // result beat
    typedef struct packed {
        logic [6:0]  segments;
        logic [2:0]  digit_select;
        logic [15:0] count_zero;
        logic [15:0] count_one;
    } out_t;

    // classified record passed from front to back
    typedef struct packed {
        logic [3:0]  digit;
        logic [2:0]  digit_select;
        logic [15:0] count_zero;
        logic [15:0] count_one;
    } rec_t;

    // four-digit bcd increment, 9999 wraps to 0000
    function automatic logic [15:0] bcd_inc(input logic [15:0] v);
        logic [15:0] r;
        logic        carry;
        r     = v;
        carry = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (carry) begin
                if (r[4*i +: 4] == 4'd9) begin
                    r[4*i +: 4] = 4'd0;
                end else begin
                    r[4*i +: 4] = r[4*i +: 4] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // common-cathode pattern of one decimal digit, bit0 is segment a
    function automatic logic [6:0] seg_pattern(input logic [3:0] d);
        logic [6:0] p;
        unique case (d)
            4'd0:    p = 7'h3f;
            4'd1:    p = 7'h06;
            4'd2:    p = 7'h5b;
            4'd3:    p = 7'h4f;
            4'd4:    p = 7'h66;
            4'd5:    p = 7'h6d;
            4'd6:    p = 7'h7d;
            4'd7:    p = 7'h07;
            4'd8:    p = 7'h7f;
            4'd9:    p = 7'h6f;
            default: p = 7'h00;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/dec7_front.sv =====
module dec7_front
    import dec7_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [15:0] cfg_data,
    input  logic        take,
    input  in_t         sample,
    output rec_t        rec
);

    logic        prev0_reg, prev0_next;
    logic        prev1_reg, prev1_next;
    logic [15:0] cnt0_reg, cnt0_next;
    logic [15:0] cnt1_reg, cnt1_next;
    logic [15:0] bcd0_reg, bcd0_next;
    logic [15:0] bcd1_reg, bcd1_next;
    logic [15:0] snap0_reg, snap0_next;
    logic [15:0] snap1_reg, snap1_next;
    logic [2:0]  scan_reg, scan_next;
    logic [15:0] dwell_cnt_reg, dwell_cnt_next;
    logic [15:0] dwell_reg, dwell_next;

    logic        edge0;
    logic        edge1;
    logic [15:0] cnt0_inc;
    logic [15:0] cnt1_inc;
    logic [15:0] limit;
    logic [16:0] dwell_inc;
    logic        advance;
    logic [15:0] snap_sel;

    // falling edge detect and running counts with bcd shadows
    always_comb
    begin
        edge0    = prev0_reg & ~sample.pin0_level;
        edge1    = prev1_reg & ~sample.pin1_level;
        cnt0_inc = cnt0_reg + 16'd1;
        cnt1_inc = cnt1_reg + 16'd1;
        cnt0_next = edge0 ? cnt0_inc : cnt0_reg;
        cnt1_next = edge1 ? cnt1_inc : cnt1_reg;
        // a binary wrap restarts the decimal view at zero
        bcd0_next = bcd0_reg;
        if (edge0)
        begin
            bcd0_next = (cnt0_inc == 16'd0) ? 16'd0 : bcd_inc(bcd0_reg);
        end
        bcd1_next = bcd1_reg;
        if (edge1)
        begin
            bcd1_next = (cnt1_inc == 16'd0) ? 16'd0 : bcd_inc(bcd1_reg);
        end
        prev0_next = sample.pin0_level;
        prev1_next = sample.pin1_level;
    end

    // dwell timing and scan advance
    always_comb
    begin
        limit     = (dwell_reg == 16'd0) ? 16'd1 : dwell_reg;
        dwell_inc = {1'b0, dwell_cnt_reg} + 17'd1;
        advance   = dwell_inc >= {1'b0, limit};
        dwell_cnt_next = advance ? 16'd0 : dwell_inc[15:0];
        scan_next      = advance ? scan_reg + 3'd1 : scan_reg;
        snap0_next     = snap0_reg;
        snap1_next     = snap1_reg;
        if (advance && scan_reg == SCAN_LAST)
        begin
            snap0_next = bcd0_next;
            snap1_next = bcd1_next;
        end
        dwell_next = cfg_valid ? cfg_data : dwell_reg;
    end

    // record for the lit digit, thousands first
    always_comb
    begin
        snap_sel = scan_reg[2] ? snap1_reg : snap0_reg;
        unique case (scan_reg[1:0])
            2'd0:    rec.digit = snap_sel[15:12];
            2'd1:    rec.digit = snap_sel[11:8];
            2'd2:    rec.digit = snap_sel[7:4];
            default: rec.digit = snap_sel[3:0];
        endcase
        rec.digit_select = scan_reg;
        rec.count_zero   = cnt0_next;
        rec.count_one    = cnt1_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev0_reg     <= 1'b1;
            prev1_reg     <= 1'b1;
            cnt0_reg      <= 16'd0;
            cnt1_reg      <= 16'd0;
            bcd0_reg      <= 16'd0;
            bcd1_reg      <= 16'd0;
            snap0_reg     <= 16'd0;
            snap1_reg     <= 16'd0;
            scan_reg      <= 3'd0;
            dwell_cnt_reg <= 16'd0;
            dwell_reg     <= DWELL_RESET;
        end
        else
        begin
            dwell_reg <= dwell_next;
            if (take)
            begin
                prev0_reg     <= prev0_next;
                prev1_reg     <= prev1_next;
                cnt0_reg      <= cnt0_next;
                cnt1_reg      <= cnt1_next;
                bcd0_reg      <= bcd0_next;
                bcd1_reg      <= bcd1_next;
                snap0_reg     <= snap0_next;
                snap1_reg     <= snap1_next;
                scan_reg      <= scan_next;
                dwell_cnt_reg <= dwell_cnt_next;
            end
        end
    end

    // scan only moves on a beat that also clears the dwell count
    a_scan_moves_with_clear: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg != $past(scan_reg) |-> dwell_cnt_reg == 16'd0 && $past(take))
        else $error("scan index moved without a dwell clear");

    // the decimal shadow only changes when the binary count does
    a_bcd_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        bcd0_reg != $past(bcd0_reg) |-> cnt0_reg != $past(cnt0_reg))
        else $error("decimal count changed without an edge");

endmodule

// ===== rtl/dec7_queue.sv =====
module dec7_queue
    import dec7_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  rec_t wr_data,
    output logic full,
    input  logic rd,
    output rec_t rd_data,
    output logic empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    rec_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // flags and pointer update
    always_comb
    begin
        full    = cnt_reg == CNT_FULL;
        empty   = cnt_reg == '0;
        rd_data = slot_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        rd_ptr_next = rd_ptr_reg;
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg;
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // record slots
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // no write into a full queue, no read from an empty one
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr && full) && !(rd && empty))
        else $error("queue overrun or underrun");

endmodule

// ===== rtl/dec7_back.sv =====
module dec7_back
    import dec7_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    input  rec_t q_data,
    output logic q_rd,
    input  logic pop,
    output logic empty,
    output out_t result
);

    logic out_valid_reg, out_valid_next;
    out_t out_reg, out_next;

    // segment decode and output register load
    always_comb
    begin
        q_rd                  = !q_empty && (!out_valid_reg || pop);
        out_next.segments     = seg_pattern(q_data.digit);
        out_next.digit_select = q_data.digit_select;
        out_next.count_zero   = q_data.count_zero;
        out_next.count_one    = q_data.count_one;
        out_valid_next = q_rd || (out_valid_reg && !pop);
        empty  = !out_valid_reg;
        result = out_reg;
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // a waiting beat that is not taken keeps its value
    a_hold_unpopped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(out_reg))
        else $error("result beat changed before it was taken");

endmodule

// ===== rtl/dual_edge_counter_7seg_scan.sv =====
// channel   direction  handshake             payload
// input     in         push / full           sample (in_t)
// result    out        pop / empty           result (out_t)
// config    in         cfg_valid / cfg_ready cfg_data (dwell_ticks)
//
// one beat in and one beat out per cycle sustained while pop is held high; an accepted
// input beat reaches the result ports through a queue slot, then the output register
// rst_n clears counts, snapshots, scan and dwell count; dwell_ticks resets to 1000
// the queue between front and back holds QUEUE_DEPTH records, full stays low
// while the result side keeps popping
// cfg_ready is always high, each write is registered straight into the dwell register
module dual_edge_counter_7seg_scan
    import dec7_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_t         sample,
    input  logic        pop,
    output logic        empty,
    output out_t        result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic take;
    rec_t rec;
    rec_t q_data;
    logic q_full;
    logic q_empty;
    logic q_rd;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign take      = push && !q_full;

    // front: edge counting and scan timing
    dec7_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .take      (take),
        .sample    (sample),
        .rec       (rec)
    );

    // queue between front and back
    dec7_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (take),
        .wr_data (rec),
        .full    (q_full),
        .rd      (q_rd),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    // back: segment decode and result register
    dec7_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

// ===== tb/tb.sv =====
module tb;
    import dec7_pkg::*;

    // stimulus patterns for the pin levels
    typedef enum int {PAT_RANDOM, PAT_TOGGLE, PAT_HOLD} pattern_e;

    // predicts the display and counts for each pin sample and holds the pending results
    class scan_scoreboard;
        logic [15:0] dwell;
        logic        prev0;
        logic        prev1;
        logic [15:0] cnt0;
        logic [15:0] cnt1;
        logic [15:0] snap0;
        logic [15:0] snap1;
        logic [2:0]  scan;
        logic [15:0] dwell_cnt;
        logic [6:0]  seg_code [10];
        int          place_value [4];
        out_t        expected_q [$];
        int          errors;
        int          checked;
        int          samples;
        int          edges0;
        int          edges1;

        function new();
            dwell       = 16'd1000;
            prev0       = 1'b1;
            prev1       = 1'b1;
            cnt0        = '0;
            cnt1        = '0;
            snap0       = '0;
            snap1       = '0;
            scan        = '0;
            dwell_cnt   = '0;
            seg_code    = '{7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07,
                            7'h7f, 7'h6f};
            place_value = '{1000, 100, 10, 1};
            errors      = 0;
            checked     = 0;
            samples     = 0;
            edges0      = 0;
            edges1      = 0;
        endfunction

        function void set_dwell(logic [15:0] v);
            dwell = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // pattern of one decimal position, thousands first, of v mod 10000
        function logic [6:0] digit_seg(logic [15:0] v, logic [1:0] pos);
            int r;
            int d;
            r = v % 10000;
            d = (r / place_value[pos]) % 10;
            return seg_code[d];
        endfunction

        function void note_sample(in_t s);
            out_t        e;
            logic [16:0] limit;
            logic [16:0] nxt;
            // falling edge detection
            if (prev0 && !s.pin0_level)
            begin
                cnt0 = cnt0 + 16'd1;
                edges0++;
            end
            if (prev1 && !s.pin1_level)
            begin
                cnt1 = cnt1 + 16'd1;
                edges1++;
            end
            prev0 = s.pin0_level;
            prev1 = s.pin1_level;
            // result from the current scan position
            e.digit_select = scan;
            if (scan < 3'd4)
                e.segments = digit_seg(snap0, scan[1:0]);
            else
                e.segments = digit_seg(snap1, scan[1:0]);
            e.count_zero = cnt0;
            e.count_one  = cnt1;
            expected_q.push_back(e);
            samples++;
            // dwell timing, zero acts as one
            limit = (dwell == 16'd0) ? 17'd1 : {1'b0, dwell};
            nxt   = {1'b0, dwell_cnt} + 17'd1;
            if (nxt >= limit)
            begin
                dwell_cnt = '0;
                scan      = scan + 3'd1;
                if (scan == 3'd0)
                begin
                    snap0 = cnt0;
                    snap1 = cnt1;
                end
            end
            else
                dwell_cnt = nxt[15:0];
        endfunction

        function void check_result(out_t got);
            out_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.segments !== e.segments)
            begin
                $display("%0t: segments expected %h got %h", $time, e.segments, got.segments);
                errors++;
            end
            if (got.digit_select !== e.digit_select)
            begin
                $display("%0t: digit_select expected %0d got %0d", $time, e.digit_select,
                         got.digit_select);
                errors++;
            end
            if (got.count_zero !== e.count_zero)
            begin
                $display("%0t: count_zero expected %0d got %0d", $time, e.count_zero,
                         got.count_zero);
                errors++;
            end
            if (got.count_one !== e.count_one)
            begin
                $display("%0t: count_one expected %0d got %0d", $time, e.count_one,
                         got.count_one);
                errors++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    in_t         sample    = '1;
    logic        pop       = 1'b0;
    logic        empty;
    out_t        result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;
    bit          idle_en   = 1'b1;

    scan_scoreboard sb = new();

    dual_edge_counter_7seg_scan uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always #6 clk = ~clk;

    // offer one sample, with an occasional gap before it
    task automatic send_sample(in_t s);
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        push   <= 1'b1;
        sample <= s;
        do @(posedge clk); while (full);
        sb.note_sample(s);
    endtask

    // stop offering and wait until every result has come out
    task automatic drain();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_dwell(logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.set_dwell(v);
        cfg_valid <= 1'b0;
    endtask

    // result side: pop with random stalls and one long hold-off
    initial
    begin
        int stall_left = 0;
        bit held       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_result(result);
            if (!held && sb.checked >= 330)
            begin
                held       = 1'b1;
                stall_left = 150;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 17);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // main sequence
    initial
    begin
        logic [1:0]  dir_a [7];
        logic [1:0]  dir_b [7];
        logic [15:0] dwell_plan [8];
        in_t         lv;
        pattern_e    mode;
        dir_a      = '{2'b11, 2'b01, 2'b00, 2'b10, 2'b11, 2'b00, 2'b11};
        dir_b      = '{2'b00, 2'b11, 2'b00, 2'b01, 2'b10, 2'b01, 2'b00};
        dwell_plan = '{16'd65535, 16'd1, 16'd2, 16'd7, 16'd0, 16'd1000, 16'd0, 16'd0};
        dwell_plan[6] = $urandom_range(3, 60);
        dwell_plan[7] = $urandom_range(61, 65534);
        lv = '1;
        mode = PAT_RANDOM;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single and joint edges at the reset dwell
        foreach (dir_a[i]) send_sample(in_t'(dir_a[i]));
        drain();
        // dwell of zero advances the scan on every sample
        write_dwell(16'd0);
        foreach (dir_b[i]) send_sample(in_t'(dir_b[i]));
        drain();
        // dwell lowered below the running dwell count
        write_dwell(16'd20);
        repeat (6) send_sample(in_t'($urandom_range(0, 3)));
        drain();
        write_dwell(16'd3);
        repeat (4) send_sample(in_t'($urandom_range(0, 3)));
        drain();

        // random samples under several dwell settings
        foreach (dwell_plan[p])
        begin
            write_dwell(dwell_plan[p]);
            for (int j = 0; j < 200; j++)
            begin
                idle_en = ((j / 50) % 2 == 0);
                if (j % 25 == 0)
                    mode = pattern_e'($urandom_range(0, 2));
                case (mode)
                    PAT_RANDOM: lv = in_t'($urandom_range(0, 3));
                    PAT_TOGGLE: lv = in_t'({~lv.pin0_level, 1'($urandom_range(0, 1))});
                    default:
                    begin
                        if ($urandom_range(0, 9) == 0)
                            lv = in_t'($urandom_range(0, 3));
                    end
                endcase
                send_sample(lv);
            end
            drain();
        end

        // full-rate toggling with no idling at the end of the run
        idle_en = 1'b0;
        write_dwell(16'd1);
        for (int k = 0; k < 40; k++)
            send_sample(in_t'({k[0], ~k[0]}));
        drain();

        $display("covered %0d samples and %0d results, %0d / %0d falling edges",
                 sb.samples, sb.checked, sb.edges0, sb.edges1);
        $display("dwell settings 0, 1, 2, 3, 7, 20, 1000, 65535 and two random values");
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #24000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
